// ===== src/mft_pkg.sv =====
package mft_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int IN_VALUE_W  = 32;
    localparam int VALUE_W     = 31;
    localparam int COUNT_W     = 32;

    typedef enum logic
    {
        OP_PUSH   = 1'b0,
        OP_FINISH = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_MODE   = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_NONPOS = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef struct packed
    {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
    } entry_t;

endpackage

// ===== src/mft_if.sv =====
interface mft_in_if;
    logic                                 valid;
    logic                                 ready;
    mft_pkg::op_t                         op;
    logic signed [mft_pkg::IN_VALUE_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface mft_out_if;
    logic                          valid;
    logic                          ready;
    logic [mft_pkg::VALUE_W-1:0]   mode_value;
    logic [mft_pkg::COUNT_W-1:0]   mode_count;
    mft_pkg::status_t              status;
    logic                          last;

    modport source (output valid, output mode_value, output mode_count, output status,
                    output last, input ready);
    modport sink   (input valid, input mode_value, input mode_count, input status,
                    input last, output ready);
endinterface

// ===== src/mode_finder_table_unit.sv =====
// Mode finder: counts positive integers and reports the most frequent ones.
// Channel req (valid/ready) carries op and value: op push adds value to a
// table of distinct values with saturating counts; op finish reports the
// modes. Channel rsp (valid/ready) carries mode_value, mode_count, status and
// last; last marks the final word caused by one request.
// A push scans the table through the single RAM read port, one entry a cycle.
// The scan of the N stored entries ends at the matching entry or, when no
// entry matches, after all N entries; a table-full push then gives a status
// word. A non-positive value skips the scan, empties the table and goes
// straight to its status word. A finish first scans all N entries to find the
// greatest count, then reads the entries up to the last mode, one word per
// mode found; a finish on an empty table gives one empty-status word. The
// table is then cleared. One request is worked on at a time; req.ready is high
// only between requests, so the next request can be taken in the cycle after
// the previous one is done.
// A word waits in the rsp output register while req takes the next request;
// when rsp stalls, the sequencer holds until the register is free.
// Reset empties the table at once (no clearing pass) and drops any held word.
module mode_finder_table_unit (
    input  logic      clk,
    input  logic      rst_n,
    mft_in_if.sink    req,
    mft_out_if.source rsp
);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_PUSH,
        S_STATUS,
        S_MAX,
        S_EMIT_RD,
        S_EMIT_CHK
    } state_t;

    state_t                        state_reg, state_next;
    logic [mft_pkg::CNT_W-1:0]     used_reg, used_next;
    logic [mft_pkg::CNT_W-1:0]     idx_reg, idx_next;
    logic                          pend_reg, pend_next;
    logic [mft_pkg::IDX_W-1:0]     pidx_reg, pidx_next;
    logic [mft_pkg::VALUE_W-1:0]   value_reg, value_next;
    logic [mft_pkg::COUNT_W-1:0]   best_reg, best_next;
    logic [mft_pkg::IDX_W-1:0]     final_reg, final_next;
    mft_pkg::status_t              stat_reg, stat_next;

    logic                          ovalid_reg, ovalid_next;
    logic [mft_pkg::VALUE_W-1:0]   ovalue_reg, ovalue_next;
    logic [mft_pkg::COUNT_W-1:0]   ocount_reg, ocount_next;
    mft_pkg::status_t              ostat_reg, ostat_next;
    logic                          olast_reg, olast_next;

    logic                          ram_we;
    logic [mft_pkg::IDX_W-1:0]     ram_waddr;
    mft_pkg::entry_t               ram_wdata;
    logic                          ram_re;
    logic [mft_pkg::IDX_W-1:0]     ram_raddr;
    mft_pkg::entry_t               ram_rdata;

    logic [mft_pkg::COUNT_W-1:0]   cmp_a;
    logic [mft_pkg::COUNT_W-1:0]   cmp_b;
    logic                          cmp_eq;
    logic                          cmp_gt;
    logic [mft_pkg::COUNT_W-1:0]   inc_count;
    logic                          out_free;
    logic                          accept;
    logic                          nonpos;

    mft_ram #(
        .WIDTH ($bits(mft_pkg::entry_t)),
        .DEPTH (mft_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared compare unit: value match during push, count against best otherwise
    always_comb
    begin
        if (state_reg == S_PUSH)
        begin
            cmp_a = {1'b0, ram_rdata.value};
            cmp_b = {1'b0, value_reg};
        end
        else
        begin
            cmp_a = ram_rdata.count;
            cmp_b = best_reg;
        end
    end

    assign cmp_eq    = (cmp_a == cmp_b);
    assign cmp_gt    = (cmp_a > cmp_b);
    assign inc_count = (&ram_rdata.count) ? ram_rdata.count
                                          : ram_rdata.count + mft_pkg::COUNT_W'(1);

    assign out_free  = !ovalid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign nonpos    = req.value[mft_pkg::IN_VALUE_W-1] || (req.value == '0);

    always_comb
    begin
        state_next  = state_reg;
        used_next   = used_reg;
        idx_next    = idx_reg;
        pend_next   = pend_reg;
        pidx_next   = pidx_reg;
        value_next  = value_reg;
        best_next   = best_reg;
        final_next  = final_reg;
        stat_next   = stat_reg;

        ovalid_next = ovalid_reg && !rsp.ready;
        ovalue_next = ovalue_reg;
        ocount_next = ocount_reg;
        ostat_next  = ostat_reg;
        olast_next  = olast_reg;

        ram_we      = 1'b0;
        ram_waddr   = pidx_reg;
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;
        ram_raddr   = idx_reg[mft_pkg::IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next  = '0;
                    pend_next = 1'b0;
                    if (req.op == mft_pkg::OP_PUSH)
                    begin
                        if (nonpos)
                        begin
                            used_next  = '0;
                            stat_next  = mft_pkg::ST_NONPOS;
                            state_next = S_STATUS;
                        end
                        else
                        begin
                            value_next = req.value[mft_pkg::VALUE_W-1:0];
                            state_next = S_PUSH;
                        end
                    end
                    else if (used_reg == '0)
                    begin
                        stat_next  = mft_pkg::ST_EMPTY;
                        state_next = S_STATUS;
                    end
                    else
                    begin
                        best_next  = '0;
                        final_next = '0;
                        state_next = S_MAX;
                    end
                end
            end

            S_PUSH:
            begin
                if (pend_reg && cmp_eq)
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = pidx_reg;
                    ram_wdata.value = ram_rdata.value;
                    ram_wdata.count = inc_count;
                    pend_next       = 1'b0;
                    state_next      = S_IDLE;
                end
                else if (!pend_reg && idx_reg == used_reg)
                begin
                    if (used_reg == mft_pkg::CNT_W'(mft_pkg::TABLE_DEPTH))
                    begin
                        stat_next  = mft_pkg::ST_FULL;
                        state_next = S_STATUS;
                    end
                    else
                    begin
                        ram_we          = 1'b1;
                        ram_waddr       = used_reg[mft_pkg::IDX_W-1:0];
                        ram_wdata.value = value_reg;
                        ram_wdata.count = mft_pkg::COUNT_W'(1);
                        used_next       = used_reg + mft_pkg::CNT_W'(1);
                        state_next      = S_IDLE;
                    end
                end
                else if (idx_reg < used_reg)
                begin
                    ram_re    = 1'b1;
                    pend_next = 1'b1;
                    pidx_next = idx_reg[mft_pkg::IDX_W-1:0];
                    idx_next  = idx_reg + mft_pkg::CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end

            S_STATUS:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ovalue_next = '0;
                    ocount_next = '0;
                    ostat_next  = stat_reg;
                    olast_next  = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            S_MAX:
            begin
                if (pend_reg)
                begin
                    if (cmp_gt)
                    begin
                        best_next  = ram_rdata.count;
                        final_next = pidx_reg;
                    end
                    else if (cmp_eq)
                    begin
                        final_next = pidx_reg;
                    end
                end
                if (idx_reg < used_reg)
                begin
                    ram_re    = 1'b1;
                    pend_next = 1'b1;
                    pidx_next = idx_reg[mft_pkg::IDX_W-1:0];
                    idx_next  = idx_reg + mft_pkg::CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        idx_next   = '0;
                        state_next = S_EMIT_RD;
                    end
                end
            end

            S_EMIT_RD:
            begin
                ram_re     = 1'b1;
                pidx_next  = idx_reg[mft_pkg::IDX_W-1:0];
                idx_next   = idx_reg + mft_pkg::CNT_W'(1);
                state_next = S_EMIT_CHK;
            end

            S_EMIT_CHK:
            begin
                if (!cmp_eq)
                begin
                    state_next = S_EMIT_RD;
                end
                else if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ovalue_next = ram_rdata.value;
                    ocount_next = best_reg;
                    ostat_next  = mft_pkg::ST_MODE;
                    olast_next  = (pidx_reg == final_reg);
                    if (pidx_reg == final_reg)
                    begin
                        used_next  = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            used_reg   <= '0;
            idx_reg    <= '0;
            pend_reg   <= 1'b0;
            pidx_reg   <= '0;
            value_reg  <= '0;
            best_reg   <= '0;
            final_reg  <= '0;
            stat_reg   <= mft_pkg::ST_MODE;
            ovalid_reg <= 1'b0;
            ovalue_reg <= '0;
            ocount_reg <= '0;
            ostat_reg  <= mft_pkg::ST_MODE;
            olast_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            idx_reg    <= idx_next;
            pend_reg   <= pend_next;
            pidx_reg   <= pidx_next;
            value_reg  <= value_next;
            best_reg   <= best_next;
            final_reg  <= final_next;
            stat_reg   <= stat_next;
            ovalid_reg <= ovalid_next;
            ovalue_reg <= ovalue_next;
            ocount_reg <= ocount_next;
            ostat_reg  <= ostat_next;
            olast_reg  <= olast_next;
        end
    end

    assign rsp.valid      = ovalid_reg;
    assign rsp.mode_value = ovalue_reg;
    assign rsp.mode_count = ocount_reg;
    assign rsp.status     = ostat_reg;
    assign rsp.last       = olast_reg;

endmodule

// ===== src/mft_ram.sv =====
module mft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sim/mode_finder_table_unit_tb.sv =====
module mode_finder_table_unit_tb;

    import mft_pkg::*;

    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 200;
    localparam int RANDOM_ITEMS  = 40;
    localparam int MAX_PRINTED   = 40;

    typedef struct packed
    {
        logic [VALUE_W-1:0] mode_value;
        logic [COUNT_W-1:0] mode_count;
        status_t            status;
        logic               last;
    } mode_word_t;

    logic clk = 1'b0;
    logic rst_n;

    mft_in_if  req();
    mft_out_if rsp();

    mode_finder_table_unit u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    logic [VALUE_W-1:0] tally_vals [TABLE_DEPTH];
    logic [COUNT_W-1:0] tally_cnts [TABLE_DEPTH];
    int                 tally_used = 0;
    mode_word_t         words_due [$];

    int mismatches  = 0;
    int items_sent  = 0;
    int words_seen  = 0;
    int idle_cycles = 0;
    int status_hits [4] = '{0, 0, 0, 0};
    bit no_gaps     = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int draw_wait();
        return no_gaps ? 0 : $urandom_range(0, 6);
    endfunction

    function automatic logic [IN_VALUE_W-1:0] positive_draw();
        logic [IN_VALUE_W-1:0] v;
        if ($urandom_range(0, 3) == 0)
        begin
            v = $urandom_range(1, 16);
        end
        else
        begin
            v = $urandom() & 32'h7FFF_FFFF;
        end
        if (v == '0)
        begin
            v = 1;
        end
        return v;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
        begin
            $display("MISMATCH at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
        end
    endtask

    task automatic emit_due(logic [VALUE_W-1:0] v, logic [COUNT_W-1:0] c, status_t st,
                            logic lst);
        mode_word_t w;
        w.mode_value = v;
        w.mode_count = c;
        w.status     = st;
        w.last       = lst;
        words_due.insert(words_due.size(), w);
    endtask

    task automatic tally_word(op_t op, logic signed [IN_VALUE_W-1:0] value);
        logic [COUNT_W-1:0] best;
        int                 final_idx;
        bit                 found;
        found     = 1'b0;
        best      = '0;
        final_idx = 0;
        if (op == OP_PUSH)
        begin
            if (value <= 0)
            begin
                tally_used = 0;
                emit_due('0, '0, ST_NONPOS, 1'b1);
            end
            else
            begin
                for (int i = 0; i < tally_used; i++)
                begin
                    if (!found && tally_vals[i] == value[VALUE_W-1:0])
                    begin
                        found = 1'b1;
                        if (tally_cnts[i] != '1)
                        begin
                            tally_cnts[i]++;
                        end
                    end
                end
                if (!found)
                begin
                    if (tally_used >= TABLE_DEPTH)
                    begin
                        emit_due('0, '0, ST_FULL, 1'b1);
                    end
                    else
                    begin
                        tally_vals[tally_used] = value[VALUE_W-1:0];
                        tally_cnts[tally_used] = 1;
                        tally_used++;
                    end
                end
            end
        end
        else if (tally_used == 0)
        begin
            emit_due('0, '0, ST_EMPTY, 1'b1);
        end
        else
        begin
            for (int i = 0; i < tally_used; i++)
            begin
                if (tally_cnts[i] > best)
                begin
                    best = tally_cnts[i];
                end
            end
            for (int i = 0; i < tally_used; i++)
            begin
                if (tally_cnts[i] == best)
                begin
                    final_idx = i;
                end
            end
            for (int i = 0; i < tally_used; i++)
            begin
                if (tally_cnts[i] == best)
                begin
                    emit_due(tally_vals[i], best, ST_MODE, i == final_idx);
                end
            end
            tally_used = 0;
        end
    endtask

    task automatic send_word(op_t op, logic [IN_VALUE_W-1:0] value);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.op    <= op;
        req.value <= value;
        do @(posedge clk); while (!req.ready);
        tally_word(op, value);
        items_sent++;
    endtask

    task automatic wait_for_words();
        req.valid <= 1'b0;
        while (words_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_empty_finish();
        send_word(OP_FINISH, 32'h0000_0000);
        send_word(OP_FINISH, 32'hFFFF_FFFF);
    endtask

    task automatic test_non_positive();
        send_word(OP_PUSH, 32'd5);
        send_word(OP_PUSH, 32'd0);
        send_word(OP_FINISH, 32'd0);
        send_word(OP_PUSH, 32'hFFFF_FFFF);
        send_word(OP_PUSH, 32'h8000_0000);
        send_word(OP_PUSH, 32'h7FFF_FFFF);
        send_word(OP_PUSH, 32'd1);
        send_word(OP_PUSH, 32'h7FFF_FFFF);
        send_word(OP_FINISH, 32'h5555_5555);
        send_word(OP_PUSH, 32'd1);
        send_word(OP_PUSH, 32'h8000_0000);
        send_word(OP_FINISH, 32'hAAAA_AAAA);
    endtask

    task automatic test_tied_modes();
        no_gaps = 1'b1;
        send_word(OP_PUSH, 32'd3);
        send_word(OP_PUSH, 32'd7);
        send_word(OP_PUSH, 32'd3);
        send_word(OP_PUSH, 32'd9);
        send_word(OP_PUSH, 32'd7);
        send_word(OP_PUSH, 32'd1);
        send_word(OP_FINISH, 32'd0);
        no_gaps = 1'b0;
        send_word(OP_PUSH, 32'd4);
        send_word(OP_PUSH, 32'd4);
        send_word(OP_PUSH, 32'd4);
        send_word(OP_FINISH, 32'd0);
        send_word(OP_PUSH, 32'h4000_0000);
        send_word(OP_FINISH, 32'd0);
    endtask

    task automatic test_table_full();
        logic [IN_VALUE_W-1:0] base;
        base = $urandom_range(1, 32'h7FFF_FF00);
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            send_word(OP_PUSH, base + i);
        end
        send_word(OP_PUSH, base + TABLE_DEPTH);
        send_word(OP_PUSH, base + 5);
        send_word(OP_PUSH, base + TABLE_DEPTH + 1);
        send_word(OP_FINISH, 32'd0);
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            send_word(OP_PUSH, base + i);
        end
        send_word(OP_PUSH, 32'h7FFF_FFFF);
        send_word(OP_FINISH, 32'd0);
    endtask

    task automatic test_random_sets();
        int                    start;
        int                    kind;
        int                    len;
        int                    pool_n;
        logic [IN_VALUE_W-1:0] pool [8];
        logic [IN_VALUE_W-1:0] v;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            no_gaps = ($urandom_range(0, 5) == 0);
            kind    = $urandom_range(0, 9);
            pool_n  = $urandom_range(1, 8);
            for (int i = 0; i < 8; i++)
            begin
                pool[i] = positive_draw();
            end
            if (kind == 0)
            begin
                send_word(op_t'($urandom_range(0, 1)), $urandom());
            end
            else if (kind == 1)
            begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                begin
                    send_word(OP_PUSH, pool[$urandom_range(0, pool_n - 1)]);
                end
                v = ($urandom_range(0, 2) == 0) ? 32'd0 : ($urandom() | 32'h8000_0000);
                send_word(OP_PUSH, v);
                if ($urandom_range(0, 1) == 1)
                begin
                    send_word(OP_PUSH, pool[0]);
                    send_word(OP_FINISH, $urandom());
                end
            end
            else if (kind == 2)
            begin
                len = $urandom_range(20, 70);
                for (int i = 0; i < len; i++)
                begin
                    send_word(OP_PUSH, positive_draw());
                end
                send_word(OP_FINISH, $urandom());
            end
            else
            begin
                len = $urandom_range(1, 16);
                for (int i = 0; i < len; i++)
                begin
                    send_word(OP_PUSH, pool[$urandom_range(0, pool_n - 1)]);
                end
                send_word(OP_FINISH, $urandom());
            end
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        int stall;
        rsp.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        rsp.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (rsp.valid && rsp.ready)
            begin
                stall = draw_wait();
                if (stall > 0)
                begin
                    rsp.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                    rsp.ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin : check_words
        mode_word_t w;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            words_seen++;
            status_hits[int'(rsp.status)]++;
            if (words_due.size() == 0)
            begin
                report_mismatch("word with nothing due, status", rsp.status, 0);
            end
            else
            begin
                w = words_due.pop_front();
                if (rsp.mode_value !== w.mode_value)
                begin
                    report_mismatch("mode_value", rsp.mode_value, w.mode_value);
                end
                if (rsp.mode_count !== w.mode_count)
                begin
                    report_mismatch("mode_count", rsp.mode_count, w.mode_count);
                end
                if (rsp.status !== w.status)
                begin
                    report_mismatch("status", rsp.status, w.status);
                end
                if (rsp.last !== w.last)
                begin
                    report_mismatch("last", rsp.last, w.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        req.valid = 1'b0;
        req.op    = OP_PUSH;
        req.value = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_finish();
        test_non_positive();
        test_tied_modes();
        wait_for_words();
        test_table_full();
        test_random_sets();
        wait_for_words();

        $display("Run: %0d request words sent, %0d result words checked.",
                 items_sent, words_seen);
        $display("Words by status: mode %0d, empty %0d, non-positive %0d, table full %0d.",
                 status_hits[ST_MODE], status_hits[ST_EMPTY], status_hits[ST_NONPOS],
                 status_hits[ST_FULL]);
        if (mismatches == 0 && words_due.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
